// ----- src/mtfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtfc_pkg
// Shared types and constants for the move-to-front coordinate lookup block.
// ----------------------------------------------------------------------------
package mtfc_pkg;

  // Sizes of the cache and of the backing table
  localparam int CACHE_DEPTH = 8;
  localparam int TABLE_DEPTH = 1024;

  localparam int TIDX_W  = $clog2(TABLE_DEPTH);
  localparam int TCNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W = 48;
  localparam int ENTRY_INDEX_W = 10;

  localparam logic [TCNT_W-1:0] TABLE_FULL = TCNT_W'(TABLE_DEPTH);

  // Result codes
  localparam logic [1:0] OUT_CACHE_HIT = 2'd0;
  localparam logic [1:0] OUT_FOUND     = 2'd1;
  localparam logic [1:0] OUT_APPENDED  = 2'd2;
  localparam logic [1:0] OUT_FULL      = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [TIDX_W-1:0]  tidx_t;

  // Request payload; packed as {z, y, x} so the struct bits form the key
  typedef struct packed {
    logic signed [15:0] coord_z;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_x;
  } req_t;

  typedef struct packed {
    logic [1:0]               outcome;
    logic [ENTRY_INDEX_W-1:0] entry_index;
  } rsp_t;

  typedef struct packed {
    coord_t coord;
    tidx_t  index;
  } cache_slot_t;

  // Cache lookup status toward the controller
  typedef struct packed {
    logic  hit;
    tidx_t index;
  } cache_hit_t;

  // Cache move-to-front command from the controller
  typedef struct packed {
    logic        en;
    cache_slot_t slot;
  } cache_upd_t;

endpackage

// ----- src/mtfc_table_ram.sv -----
// ----------------------------------------------------------------------------
// mtfc_table_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mtfc_table_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/mtfc_cache.sv -----
// ----------------------------------------------------------------------------
// mtfc_cache
// Small move-to-front cache: parallel lookup from the front and a shift
// update that stops at the first empty slot or at the looked-up entry.
// ----------------------------------------------------------------------------
module mtfc_cache (
  input  logic                   clk,
  input  logic                   rst,
  input  mtfc_pkg::coord_t       key,
  output mtfc_pkg::cache_hit_t   hit_info,
  input  mtfc_pkg::cache_upd_t   upd
);

  mtfc_pkg::cache_slot_t              entries [mtfc_pkg::CACHE_DEPTH];
  logic [mtfc_pkg::CACHE_DEPTH-1:0]   valid;
  logic [mtfc_pkg::CACHE_DEPTH-1:0]   move;

  // Find the first valid matching slot, counting from the front
  always_comb begin
    hit_info = '0;
    for (int i = mtfc_pkg::CACHE_DEPTH - 1; i >= 0; i--) begin
      if (valid[i] && entries[i].coord == key) begin
        hit_info.hit   = 1'b1;
        hit_info.index = entries[i].index;
      end
    end
  end

  // Mark slots that take their front neighbor; the shift stops after an
  // empty slot or after the slot holding the incoming entry
  always_comb begin
    move    = '0;
    move[0] = 1'b1;
    for (int j = 1; j < mtfc_pkg::CACHE_DEPTH; j++) begin
      move[j] = move[j-1] && valid[j-1] && (entries[j-1] != upd.slot);
    end
  end

  // Shift entries back and place the new front
  always_ff @(posedge clk) begin
    if (upd.en) begin
      entries[0] <= upd.slot;
      for (int j = 1; j < mtfc_pkg::CACHE_DEPTH; j++) begin
        if (move[j]) begin
          entries[j] <= entries[j-1];
        end
      end
    end
  end

  // Valid bits: the front fills, moved slots inherit a set bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (upd.en) begin
      valid <= valid | move;
    end
  end

endmodule

// ----- src/mtf_cached_coord_lookup.sv -----
// ----------------------------------------------------------------------------
// mtf_cached_coord_lookup
// Coordinate lookup through a move-to-front cache in front of a table of
// every coordinate created so far.
//
// Request channel (req_valid/req_ready/req) carries one signed x, y, z
// coordinate. Response channel (rsp_valid/rsp_ready/rsp) returns one result
// per request: outcome (cache hit, found in table, appended, table full) and
// the table index of the entry (zero when the table is full).
// One request is worked on at a time; the next is taken once the result
// has moved to the output register. A cache hit needs no table read. A
// miss scans the table RAM one entry per cycle through its single read
// port, from entry 0 up to the first match or the last stored entry; a
// match gives a find, no match an append or a full result.
// Reset empties the cache and the table; no clearing pass is needed.
// The response sits in an output register; while the receiver stalls a
// new request is still taken and worked on, and its result waits in the
// controller until the output register is free.
// ----------------------------------------------------------------------------
module mtf_cached_coord_lookup (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  mtfc_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output mtfc_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                        state;
  mtfc_pkg::coord_t              key;
  logic [mtfc_pkg::TCNT_W-1:0]   count;
  logic [mtfc_pkg::TCNT_W-1:0]   scan_addr;
  mtfc_pkg::tidx_t               pend_addr;
  mtfc_pkg::rsp_t                res;

  mtfc_pkg::cache_hit_t          hit_info;
  mtfc_pkg::cache_upd_t          upd;
  mtfc_pkg::coord_t              rd_data;
  logic                          rd_en;
  mtfc_pkg::tidx_t               rd_addr;
  logic                          wr_en;
  logic                          table_match;
  logic                          scan_end;
  logic                          table_full;

  mtfc_cache u_cache (
    .clk      (clk),
    .rst      (rst),
    .key      (key),
    .hit_info (hit_info),
    .upd      (upd)
  );

  mtfc_table_ram #(
    .WIDTH (mtfc_pkg::COORD_W),
    .DEPTH (mtfc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[mtfc_pkg::TIDX_W-1:0]),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready  = (state == S_IDLE);
  assign table_full = (count == mtfc_pkg::TABLE_FULL);
  assign table_match = (state == S_SCAN) && (rd_data == key);

  // Scan ends without a match: empty table on a cache miss, or last entry
  // checked in the scan
  always_comb begin
    scan_end = 1'b0;
    if (state == S_LOOK) begin
      scan_end = !hit_info.hit && (count == '0);
    end else if (state == S_SCAN) begin
      scan_end = !table_match && (scan_addr == count);
    end
  end

  // Issue table reads: entry 0 on a miss, then one entry per cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == S_LOOK) begin
      rd_en = !hit_info.hit && (count != '0);
    end else if (state == S_SCAN) begin
      rd_en   = !table_match && (scan_addr != count);
      rd_addr = scan_addr[mtfc_pkg::TIDX_W-1:0];
    end
  end

  // Append the new coordinate when the scan misses and there is room
  assign wr_en = scan_end && !table_full;

  // Move the entry to the cache front on a hit or a table find
  always_comb begin
    upd = '0;
    if (state == S_LOOK && hit_info.hit) begin
      upd.en         = 1'b1;
      upd.slot.coord = key;
      upd.slot.index = hit_info.index;
    end else if (table_match) begin
      upd.en         = 1'b1;
      upd.slot.coord = key;
      upd.slot.index = pend_addr;
    end
  end

  // Control, counters and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_addr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Load the output register when free, drop valid once taken
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            key   <= req;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (hit_info.hit) begin
            res.outcome     <= mtfc_pkg::OUT_CACHE_HIT;
            res.entry_index <= mtfc_pkg::ENTRY_INDEX_W'(hit_info.index);
            state           <= S_DONE;
          end else if (scan_end) begin
            res.outcome     <= mtfc_pkg::OUT_APPENDED;
            res.entry_index <= '0;
            count           <= count + 1'b1;
            state           <= S_DONE;
          end else begin
            pend_addr <= '0;
            scan_addr <= mtfc_pkg::TCNT_W'(1);
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (table_match) begin
            res.outcome     <= mtfc_pkg::OUT_FOUND;
            res.entry_index <= mtfc_pkg::ENTRY_INDEX_W'(pend_addr);
            state           <= S_DONE;
          end else if (scan_end) begin
            if (table_full) begin
              res.outcome     <= mtfc_pkg::OUT_FULL;
              res.entry_index <= '0;
            end else begin
              res.outcome     <= mtfc_pkg::OUT_APPENDED;
              res.entry_index <=
                mtfc_pkg::ENTRY_INDEX_W'(count[mtfc_pkg::TIDX_W-1:0]);
              count           <= count + 1'b1;
            end
            state <= S_DONE;
          end else begin
            pend_addr <= scan_addr[mtfc_pkg::TIDX_W-1:0];
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The scan pointer stays between 1 and the table count
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (scan_addr <= count) && (scan_addr != '0))
    else $error("scan pointer outside the filled table");

  // A full result only comes from a full table, with index zero
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res.outcome == mtfc_pkg::OUT_FULL |->
      table_full && (res.entry_index == '0))
    else $error("full result while the table has room");

  // An appended entry is the last one in the table
  a_append_index: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res.outcome == mtfc_pkg::OUT_APPENDED |->
      res.entry_index == mtfc_pkg::ENTRY_INDEX_W'(count - 1'b1))
    else $error("appended index does not match the table count");

  // The table count never moves during a cache hit or table find
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    upd.en |=> count == $past(count))
    else $error("table count changed on a cache update");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mtf_cached_coord_lookup. A scoreboard object keeps
// its own copy of the move-to-front cache and the backing table, predicts the
// outcome and table index of every accepted request, and compares each
// response field by field in order. Stimulus walks the corner coordinates and
// cache-shift cases, then mixes random, repeated, near-miss and small
// coordinates while the table grows.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int RECENT_DEPTH = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int MAX_REPORTS  = 10;

  // Predict lookup results and check responses against them
  class coord_lookup_scoreboard;
    mtfc_pkg::cache_slot_t slots[mtfc_pkg::CACHE_DEPTH];
    bit                    slot_live[mtfc_pkg::CACHE_DEPTH];
    mtfc_pkg::coord_t      table_coord[mtfc_pkg::TABLE_DEPTH];
    int unsigned           table_count;
    mtfc_pkg::rsp_t        awaited_results[$];
    int                    errors, results, requests;
    int                    hits, finds, appends, fulls;

    function new();
      for (int i = 0; i < mtfc_pkg::CACHE_DEPTH; i++) begin
        slots[i] = '0;
        slot_live[i] = 1'b0;
      end
      table_count = 0;
    endfunction

    // Push an entry to the front; stop at a free slot or at the entry's old place
    function void move_front(mtfc_pkg::cache_slot_t item);
      mtfc_pkg::cache_slot_t carry, old;
      bit                    carry_live, old_live;
      carry = item;
      carry_live = 1'b1;
      for (int i = 0; i < mtfc_pkg::CACHE_DEPTH; i++) begin
        old = slots[i];
        old_live = slot_live[i];
        slots[i] = carry;
        slot_live[i] = carry_live;
        carry = old;
        carry_live = old_live;
        if (!carry_live || carry == item) break;
      end
    endfunction

    // Resolve one accepted request and queue its expected response
    function void note_request(mtfc_pkg::req_t r);
      mtfc_pkg::coord_t      key;
      mtfc_pkg::cache_slot_t found;
      mtfc_pkg::rsp_t        res;
      bit                    done;
      key = mtfc_pkg::coord_t'(r);
      done = 1'b0;
      res = '0;
      requests++;
      for (int i = 0; i < mtfc_pkg::CACHE_DEPTH && !done; i++) begin
        if (slot_live[i] && slots[i].coord == key) begin
          found = slots[i];
          move_front(found);
          res.outcome = mtfc_pkg::OUT_CACHE_HIT;
          res.entry_index = found.index;
          hits++;
          done = 1'b1;
        end
      end
      for (int i = 0; i < int'(table_count) && !done; i++) begin
        if (table_coord[i] == key) begin
          found.coord = key;
          found.index = mtfc_pkg::tidx_t'(i);
          move_front(found);
          res.outcome = mtfc_pkg::OUT_FOUND;
          res.entry_index = found.index;
          finds++;
          done = 1'b1;
        end
      end
      if (!done) begin
        if (table_count < mtfc_pkg::TABLE_DEPTH) begin
          table_coord[table_count] = key;
          res.outcome = mtfc_pkg::OUT_APPENDED;
          res.entry_index = mtfc_pkg::ENTRY_INDEX_W'(table_count);
          table_count++;
          appends++;
        end else begin
          res.outcome = mtfc_pkg::OUT_FULL;
          res.entry_index = '0;
          fulls++;
        end
      end
      awaited_results = {awaited_results, res};
    endfunction

    // Compare one response with the oldest expectation
    function void check_result(mtfc_pkg::rsp_t got);
      mtfc_pkg::rsp_t want;
      results++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("response %0d with nothing expected: outcome %0d index %0d",
                   results, got.outcome, got.entry_index);
        return;
      end
      want = awaited_results.pop_front();
      if (got.outcome !== want.outcome || got.entry_index !== want.entry_index) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("response %0d mismatch: expected outcome %0d index %0d, got outcome %0d index %0d",
                   results, want.outcome, want.entry_index, got.outcome, got.entry_index);
      end
    endfunction
  endclass

  bit             clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  mtfc_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  mtfc_pkg::rsp_t rsp;

  coord_lookup_scoreboard sb = new();

  mtfc_pkg::req_t recent[$];
  bit   quiet;
  bit   held;
  int   hold_left;
  int   cycle_count;

  mtf_cached_coord_lookup DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // Drive response ready: random stalls, one long hold-off, none while quiet
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else if (!held && sb.results >= HOLD_AFTER) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end
  end

  // Check every accepted response
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic mtfc_pkg::req_t mk_coord(int x, int y, int z);
    mtfc_pkg::req_t r;
    r.coord_x = 16'(x);
    r.coord_y = 16'(y);
    r.coord_z = 16'(z);
    return r;
  endfunction

  function automatic logic [15:0] small_val();
    return 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  // Offer one request, hold it until taken, then record it
  task automatic send_req(input mtfc_pkg::req_t r);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 13) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    recent = {recent, r};
    if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
  endtask

  // Send a mix of fresh, repeated, stored, near-miss and small coordinates
  task automatic run_mix(input int count);
    mtfc_pkg::req_t r;
    int   pick;
    int   bit_pos;
    logic [47:0] raw;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      raw = {16'($urandom), 16'($urandom), 16'($urandom)};
      r = mtfc_pkg::req_t'(raw);
      if (pick < 55 && pick >= 25 && recent.size() > 0) begin
        r = recent[$urandom_range(0, recent.size() - 1)];
      end else if (pick < 90 && pick >= 55 && sb.table_count > 0) begin
        r = mtfc_pkg::req_t'(sb.table_coord[$urandom_range(0, sb.table_count - 1)]);
        if (pick >= 78) begin
          bit_pos = $urandom_range(0, mtfc_pkg::COORD_W - 1);
          raw = mtfc_pkg::coord_t'(r);
          raw[bit_pos] = ~raw[bit_pos];
          r = mtfc_pkg::req_t'(raw);
        end
      end else if (pick >= 90) begin
        r.coord_x = small_val();
        r.coord_y = small_val();
        r.coord_z = small_val();
      end
      send_req(r);
    end
  endtask

  initial begin
    mtfc_pkg::req_t corner[10];

    corner[0] = mk_coord(0, 0, 0);
    corner[1] = mk_coord(-32768, -32768, -32768);
    corner[2] = mk_coord(32767, 32767, 32767);
    corner[3] = mk_coord(-1, -1, -1);
    corner[4] = mk_coord(1, 0, -1);
    corner[5] = mk_coord(-32768, 32767, 0);
    corner[6] = mk_coord(32767, -32768, -1);
    corner[7] = mk_coord(0, 0, 1);
    corner[8] = mk_coord(1, 0, 0);
    corner[9] = mk_coord(0, 1, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Append the corners, then find them: fill the cache, then drop its tail
    for (int i = 0; i < 10; i++) send_req(corner[i]);
    for (int i = 0; i < 9; i++) send_req(corner[i]);
    // Hit mid-cache, at the front, and in the last slot
    send_req(corner[4]);
    send_req(corner[4]);
    send_req(corner[1]);
    // Find the entry that was dropped
    send_req(corner[0]);

    // Random mix with a stretch of no idling on either side
    run_mix(300);
    quiet = 1'b1;
    run_mix(150);
    quiet = 1'b0;
    run_mix(377);

    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (mtfc_pkg::TABLE_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests: %0d cache hits, %0d table finds, %0d appends, %0d table full",
             sb.requests, sb.hits, sb.finds, sb.appends, sb.fulls);
    $display("table reached %0d entries; %0d responses checked, %0d errors",
             sb.table_count, sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
